@@ rtl/csfrp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfrp_pkg
// Shared types and constants for the checksum frame resync parser.
// ----------------------------------------------------------------------------
package csfrp_pkg;

    localparam int FRAME_LEN = 9;
    localparam int WIN_LEN   = FRAME_LEN - 1;
    localparam int COUNT_W   = $clog2(WIN_LEN + 1);
    localparam int IDX_W     = $clog2(WIN_LEN);

    localparam logic [7:0] CMD_SAMPLE = 8'h48;
    localparam logic [7:0] CMD_CLOCK  = 8'h50;

    localparam int TDATA_W = 64;
    localparam int TUSER_W = 2;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_CLOCK  = 2'd1,
        KIND_OTHER  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       frame_kind;
        logic [15:0] tick_count;
        logic [31:0] epoch_count;
        logic [7:0]  value_byte;
        logic [7:0]  command_code;
    } t_frame;

endpackage

@@ rtl/csfrp_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfrp_in_reg
// Input register: holds one received byte until the window stage takes it.
// ----------------------------------------------------------------------------
module csfrp_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data,
    output logic       o_valid,
    output logic [7:0] o_data,
    input  logic       i_take
);
    logic       r_valid;
    logic [7:0] r_data;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

endmodule

@@ rtl/csfrp_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfrp_window
// Byte window, checksum test and frame decode; one byte per enabled cycle.
// ----------------------------------------------------------------------------
module csfrp_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [7:0]        i_byte,
    output logic              o_push,
    output csfrp_pkg::t_frame o_frame
);
    import csfrp_pkg::*;

    logic [7:0]         r_win [WIN_LEN];
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               w_full;
    logic [7:0]         w_sum;
    logic               w_match;

    assign w_full = (r_count >= COUNT_W'(WIN_LEN));

    // Sum of bytes 1 to 7, wrapping at 8 bits
    assign w_sum = ((r_win[1] + r_win[2]) + (r_win[3] + r_win[4]))
                 + ((r_win[5] + r_win[6]) + r_win[7]);

    assign w_match = w_full && (w_sum == i_byte);
    assign o_push  = i_en && w_match;

    always_comb begin
        o_frame.command_code = r_win[0];
        o_frame.value_byte   = r_win[1];
        o_frame.epoch_count  = {r_win[5], r_win[4], r_win[3], r_win[2]};
        o_frame.tick_count   = {r_win[7], r_win[6]};
        case (r_win[0])
            CMD_SAMPLE: o_frame.frame_kind = KIND_SAMPLE;
            CMD_CLOCK:  o_frame.frame_kind = KIND_CLOCK;
            default:    o_frame.frame_kind = KIND_OTHER;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (i_en) begin
            if (!w_full) begin
                n_count = r_count + COUNT_W'(1);
            end else if (w_match) begin
                n_count = '0;
            end else begin
                n_count = COUNT_W'(WIN_LEN);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Mismatch on a full window: drop the oldest byte and slide
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!w_full) begin
                r_win[r_count[IDX_W-1:0]] <= i_byte;
            end else if (!w_match) begin
                for (int k = 0; k < WIN_LEN - 1; k++) begin
                    r_win[k] <= r_win[k+1];
                end
                r_win[WIN_LEN-1] <= i_byte;
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(WIN_LEN))
        else $error("window count out of range");

    a_push_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_count == '0))
        else $error("window not emptied after frame");

    a_slide_keeps_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && w_full && !o_push) |=> (r_count == COUNT_W'(WIN_LEN)))
        else $error("window lost fill after slide");

endmodule

@@ rtl/csfrp_out_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfrp_out_buf
// Two-entry output buffer: result register plus skid register.
// ----------------------------------------------------------------------------
module csfrp_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  csfrp_pkg::t_frame i_frame,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output csfrp_pkg::t_frame o_frame
);
    import csfrp_pkg::*;

    logic   r_main_valid;
    logic   r_skid_valid;
    t_frame r_main;
    t_frame r_skid;
    logic   w_pop;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_frame = r_main;
    assign w_pop   = r_main_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_frame;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid <= i_frame;
            end else begin
                r_main <= i_frame;
            end
        end
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held without result entry");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("result pushed into full buffer");

    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && r_skid_valid) |=> (r_main_valid && !r_skid_valid))
        else $error("skid entry lost on transaction");

endmodule

@@ rtl/checksum_frame_resync_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksum_frame_resync_parser
// Sliding-window additive checksum frame sync over a received byte stream.
//
// Channel   Dir  Signals                         Payload
// s         in   i_s_tvalid o_s_tready i_s_tdata  rx_byte
// m         out  o_m_tvalid i_m_tready o_m_tdata  frame fields, kind in o_m_tuser
//
// One byte per cycle sustained while the output buffer has room: input register, one window update per cycle.
// A frame is decoded as its last byte leaves the input register, then registered in the output buffer for m.
// Synchronous active-low reset empties the window and the buffers.
// A two-entry output buffer lets input continue while a frame waits;
// s stalls only when both entries are full.
// ----------------------------------------------------------------------------
module checksum_frame_resync_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,  // [7:0] rx_byte
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [7:0] command_code, [15:8] value_byte, [47:16] epoch_count, [63:48] tick_count
    output logic [csfrp_pkg::TDATA_W-1:0] o_m_tdata,
    output logic [csfrp_pkg::TUSER_W-1:0] o_m_tuser   // [1:0] frame_kind
);
    import csfrp_pkg::*;

    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_buf_ready;
    logic       w_take;
    logic       w_push;
    t_frame     w_frame;
    t_frame     w_out;

    assign w_take = w_in_valid && w_buf_ready;

    csfrp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .o_valid (w_in_valid),
        .o_data  (w_in_byte),
        .i_take  (w_take)
    );

    csfrp_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_take),
        .i_byte  (w_in_byte),
        .o_push  (w_push),
        .o_frame (w_frame)
    );

    csfrp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_frame),
        .o_ready (w_buf_ready),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_frame (w_out)
    );

    assign o_m_tdata = {w_out.tick_count, w_out.epoch_count,
                        w_out.value_byte, w_out.command_code};
    assign o_m_tuser = w_out.frame_kind;

endmodule
